// ===== design/mbrr_pkg.sv =====
// shared types, constants and the crc byte update for the modbus read responder
// no dependencies; imported by every module of the block
package mbrr_pkg;

   // frame layout
   localparam int unsigned FRAME_LEN   = 6;
   localparam int unsigned CRC_LEN     = 4;
   localparam int unsigned STORE_DEPTH = FRAME_LEN - 1;
   localparam int unsigned COUNT_WIDTH = $clog2(FRAME_LEN);
   localparam int unsigned QUEUE_DEPTH = 2;

   // crc and protocol constants
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'hA001;
   localparam logic [7:0]  FUNC_READ   = 8'h04;
   localparam logic [7:0]  SLAVE_RESET = 8'h05;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   // positions within a frame, request and reply alike
   localparam count_type POS_ADDR    = 3'd0;
   localparam count_type POS_FUNC    = 3'd1;
   localparam count_type POS_DATA_HI = 3'd2;
   localparam count_type POS_DATA_LO = 3'd3;
   localparam count_type POS_CRC_LO  = 3'd4;
   localparam count_type POS_CRC_HI  = 3'd5;
   localparam count_type POS_LAST    = COUNT_WIDTH'(FRAME_LEN - 1);
   localparam count_type POS_CRC_END = COUNT_WIDTH'(CRC_LEN);

   // input item kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TEMP = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [7:0]  rx_data;
      logic [15:0] temperature;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
   } rsp_type;

   // reply job handed from front to back
   typedef struct packed {
      logic [7:0]  address;
      logic [15:0] temperature;
   } job_type;

   // queue status seen by the front end
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // one byte through the reflected modbus crc, unrolled over eight bits
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== design/mbrr_front.sv =====
// front end: takes request words, holds temperature and address, checks frames
// depends on mbrr_pkg; pushes reply jobs into mbrr_queue
module mbrr_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  mbrr_pkg::req_type           req_data,
   input  logic                        csr_valid,
   input  logic [7:0]                  csr_data,
   input  mbrr_pkg::queue_status_type  queue_status,
   output logic                        push_valid,
   output mbrr_pkg::job_type           push_data
);
   import mbrr_pkg::*;

   logic [7:0]  slave_address_ff, slave_address_in;
   logic [15:0] held_temp_ff, held_temp_in;
   count_type   byte_count_ff, byte_count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  frame_store_ff [STORE_DEPTH];

   logic accept;
   logic is_byte;
   logic last_byte;
   logic store_we;
   logic frame_ok;

   // one word accepted per cycle while the queue has room
   assign req_ready = !queue_status.full;
   assign accept    = req_valid && req_ready;
   assign is_byte   = req_data.kind == KIND_BYTE;
   assign last_byte = byte_count_ff == POS_LAST;
   assign store_we  = accept && is_byte && !last_byte;

   // frame check on the sixth byte
   assign frame_ok = (frame_store_ff[POS_CRC_LO] == crc_ff[7:0])
                  && (req_data.rx_data == crc_ff[15:8])
                  && (frame_store_ff[POS_ADDR] == slave_address_ff)
                  && (frame_store_ff[POS_FUNC] == FUNC_READ)
                  && (frame_store_ff[POS_DATA_LO] == 8'h00);

   assign push_valid            = accept && is_byte && last_byte && frame_ok;
   assign push_data.address     = slave_address_ff;
   assign push_data.temperature = held_temp_ff;

   // next state of address, temperature, count and crc
   always_comb begin
      slave_address_in = slave_address_ff;
      held_temp_in     = held_temp_ff;
      byte_count_in    = byte_count_ff;
      crc_in           = crc_ff;
      if (csr_valid) begin
         slave_address_in = csr_data;
      end
      if (accept) begin
         if (!is_byte) begin
            held_temp_in = req_data.temperature;
         end else if (last_byte) begin
            byte_count_in = '0;
            crc_in        = CRC_INIT;
         end else begin
            byte_count_in = byte_count_ff + 1'b1;
            if (byte_count_ff < POS_CRC_END) begin
               crc_in = crc_feed(crc_ff, req_data.rx_data);
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= SLAVE_RESET;
         held_temp_ff     <= '0;
         byte_count_ff    <= '0;
         crc_ff           <= CRC_INIT;
      end else begin
         slave_address_ff <= slave_address_in;
         held_temp_ff     <= held_temp_in;
         byte_count_ff    <= byte_count_in;
         crc_ff           <= crc_in;
      end
   end

   // frame byte store, no reset
   always_ff @(posedge clock) begin
      if (store_we) begin
         frame_store_ff[byte_count_ff] <= req_data.rx_data;
      end
   end

endmodule

// ===== design/mbrr_queue.sv =====
// small job queue between the frame checker and the reply sender
// depends on mbrr_pkg for the job type
module mbrr_queue #(
   parameter int unsigned Depth = mbrr_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  mbrr_pkg::job_type           push_data,
   output mbrr_pkg::queue_status_type  status,
   output logic                        pop_valid,
   output mbrr_pkg::job_type           pop_data,
   input  logic                        pop_ready
);
   import mbrr_pkg::*;

   localparam int unsigned PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CountWidth = $clog2(Depth + 1);

   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   job_type               store_ff [Depth];

   logic do_push;
   logic do_pop;

   assign status.full  = count_ff == CountWidth'(Depth);
   assign status.empty = count_ff == '0;
   assign pop_valid    = !status.empty;
   assign pop_data     = store_ff[rd_ptr_ff];
   assign do_push      = push_valid && !status.full;
   assign do_pop       = pop_valid && pop_ready;

   // pointer and fill count update with wrap at depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/mbrr_back.sv =====
// back end: turns one reply job into six reply words with a running crc
// depends on mbrr_pkg; pops jobs from mbrr_queue
module mbrr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  mbrr_pkg::job_type  job_data,
   output logic               job_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mbrr_pkg::rsp_type  rsp_data
);
   import mbrr_pkg::*;

   count_type   pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic       load;
   logic [7:0] next_byte;

   // output register refills when empty or being taken
   assign load    = job_valid && (!rsp_valid_ff || rsp_ready);
   assign job_pop = load && (pos_ff == POS_LAST);

   // reply byte for the current position
   always_comb begin
      unique case (pos_ff)
         POS_ADDR:    next_byte = job_data.address;
         POS_FUNC:    next_byte = FUNC_READ;
         POS_DATA_HI: next_byte = job_data.temperature[15:8];
         POS_DATA_LO: next_byte = job_data.temperature[7:0];
         POS_CRC_LO:  next_byte = crc_ff[7:0];
         POS_CRC_HI:  next_byte = crc_ff[15:8];
         default:     next_byte = '0;
      endcase
   end

   // position, crc and output register next values
   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.tx_byte  = next_byte;
         rsp_data_in.last     = pos_ff == POS_LAST;
         if (pos_ff == POS_LAST) begin
            pos_in = '0;
            crc_in = CRC_INIT;
         end else begin
            pos_in = pos_ff + 1'b1;
            if (pos_ff < POS_CRC_END) begin
               crc_in = crc_feed(crc_ff, next_byte);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         crc_ff       <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload register, no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/modbus_rtu_read_responder.sv =====
// Modbus RTU read responder: a slave that answers read-input requests with
// the held temperature word. Request words are either a received serial byte
// (kind 0) or a temperature update (kind 1). Bytes form fixed six-byte frames;
// a frame whose CRC16, address, function 0x04 and zero fourth byte all match
// is answered with six reply words: address, function, temperature high and
// low, CRC low, CRC high, the final one flagged by last. Failing frames are
// dropped. The csr channel writes the station address (reset value 5).
// Throughput: one request word per cycle while the job queue has room, and
// one reply word per cycle while rsp_ready is high and a job is queued; the
// crc is a byte-wide update in both the frame checker and the reply sender.
// After the sixth frame byte is taken, its job passes through the job queue
// and then the reply register before the first reply word is valid.
// A stalled receiver holds the reply register; further requests are still
// taken until the job queue between checker and sender is full, then
// req_ready drops. Reset is synchronous: frame count, crc, temperature and
// queue clear, the address returns to 5. csr_ready is always high.
// depends on mbrr_pkg, mbrr_front, mbrr_queue and mbrr_back
module modbus_rtu_read_responder #(
   parameter int unsigned QueueDepth = mbrr_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mbrr_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mbrr_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_data
);
   import mbrr_pkg::*;

   queue_status_type queue_status;
   logic             push_valid;
   job_type          push_data;
   logic             job_valid;
   job_type          job_data;
   logic             job_pop;

   assign csr_ready = 1'b1;

   // frame checker
   mbrr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .csr_valid    (csr_valid),
      .csr_data     (csr_data),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_data    (push_data)
   );

   // reply job queue
   mbrr_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .status     (queue_status),
      .pop_valid  (job_valid),
      .pop_data   (job_data),
      .pop_ready  (job_pop)
   );

   // reply sender
   mbrr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== design/mbrr_checker.sv =====
// port-level checks on the reply stream of the modbus read responder
// depends on mbrr_pkg; bound to modbus_rtu_read_responder below
module mbrr_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input mbrr_pkg::rsp_type  rsp_data
);
   import mbrr_pkg::*;

   count_type pos_ff, pos_in;

   // position of the next reply word within its reply
   always_comb begin
      pos_in = pos_ff;
      if (rsp_valid && rsp_ready) begin
         pos_in = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // stalled reply word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("reply word changed while stalled");

   // last marks exactly the sixth word
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (pos_ff == POS_LAST)))
      else $error("last flag out of place");

   // second word is always the read function code
   a_func: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (pos_ff == POS_FUNC) |-> rsp_data.tx_byte == FUNC_READ)
      else $error("function code wrong in reply");

   // nothing shown straight after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("reply valid after reset");

endmodule

bind modbus_rtu_read_responder mbrr_checker u_mbrr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
